// ----- rtl/core/isrch_pkg.sv -----
`timescale 1ns / 1ps

package isrch_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;

  localparam int KEY_W   = 32;
  localparam int IDX_W   = 10;
  localparam int SIZE_W  = 11;
  localparam int PROBE_W = 11;
  localparam int WIN_W   = SIZE_W + 1;
  localparam int QUO_W   = SIZE_W;
  localparam int PROD_W  = QUO_W + KEY_W;
  localparam int CNT_W   = $clog2(QUO_W);

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_RANGE,
    ST_MUL,
    ST_DIV,
    ST_SUM,
    ST_POS,
    ST_CMP,
    ST_ONE,
    ST_DONE
  } isrch_state_t;

  typedef enum logic [1:0] {
    ADDR_LO,
    ADDR_HI,
    ADDR_POS
  } addr_sel_t;

  typedef struct packed {
    logic      start;
    logic      write;
    addr_sel_t addr_sel;
    logic      cap_lo;
    logic      cap_hi;
    logic      count_probe;
    logic      pos_from_lo;
    logic      mul_load;
    logic      div_step;
    logic      pos_from_sum;
    logic      narrow;
    logic      set_found;
    logic      load_out;
  } isrch_cmd_t;

  typedef struct packed {
    logic is_search;
    logic n_zero;
    logic n_one;
    logic win_empty;
    logic out_range;
    logic ends_equal;
    logic div_last;
    logic hit;
    logic out_free;
  } isrch_status_t;

endpackage

// ----- rtl/core/isrch_if.sv -----
`timescale 1ns / 1ps

interface isrch_req_if import isrch_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [IDX_W-1:0]        entry_index;
  logic signed [KEY_W-1:0] key_value;

  modport source (output valid, command, entry_index, key_value, input ready);
  modport sink (input valid, command, entry_index, key_value, output ready);
endinterface

interface isrch_rsp_if import isrch_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [IDX_W-1:0]   position;
  logic [PROBE_W-1:0] probes;

  modport source (output valid, found, position, probes, input ready);
  modport sink (input valid, found, position, probes, output ready);
endinterface

// ----- rtl/core/isrch_ram.sv -----
`timescale 1ns / 1ps

module isrch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/isrch_ctrl.sv -----
`timescale 1ns / 1ps

module isrch_ctrl import isrch_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  isrch_status_t st,
  output isrch_cmd_t    cmd
);

  isrch_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.addr_sel = ADDR_LO;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (st.is_search) begin
            cmd.start  = 1'b1;
            state_next = st.n_zero ? ST_DONE : ST_LO;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_LO: begin
        cmd.addr_sel = ADDR_LO;
        if (st.win_empty) begin
          state_next = ST_DONE;
        end else if (st.n_one) begin
          state_next = ST_ONE;
        end else begin
          state_next = ST_HI;
        end
      end
      ST_HI: begin
        cmd.addr_sel = ADDR_HI;
        cmd.cap_lo   = 1'b1;
        state_next   = ST_RANGE;
      end
      ST_RANGE: begin
        cmd.cap_hi = 1'b1;
        if (st.out_range) begin
          state_next = ST_DONE;
        end else begin
          cmd.count_probe = 1'b1;
          if (st.ends_equal) begin
            cmd.pos_from_lo = 1'b1;
            state_next      = ST_POS;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.pos_from_sum = 1'b1;
        state_next       = ST_POS;
      end
      ST_POS: begin
        cmd.addr_sel = ADDR_POS;
        state_next   = ST_CMP;
      end
      ST_CMP: begin
        if (st.hit) begin
          cmd.set_found = 1'b1;
          state_next    = ST_DONE;
        end else begin
          cmd.narrow = 1'b1;
          state_next = ST_LO;
        end
      end
      ST_ONE: begin
        cmd.set_found = st.hit;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/isrch_dpath.sv -----
`timescale 1ns / 1ps

module isrch_dpath import isrch_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [SIZE_W-1:0]       cfg_wr_data,
  input  logic                    req_command,
  input  logic [IDX_W-1:0]        req_entry_index,
  input  logic signed [KEY_W-1:0] req_key_value,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output logic                    rsp_found,
  output logic [IDX_W-1:0]        rsp_position,
  output logic [PROBE_W-1:0]      rsp_probes,
  input  isrch_cmd_t              cmd,
  output isrch_status_t           st
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [SIZE_W-1:0]       table_size;
  logic [SIZE_W-1:0]       n_eff;
  logic signed [KEY_W-1:0] key;
  logic signed [KEY_W-1:0] vlo;
  logic signed [KEY_W-1:0] vhi;
  logic signed [WIN_W-1:0] lo;
  logic signed [WIN_W-1:0] hi;
  logic signed [WIN_W-1:0] pos;
  logic signed [WIN_W-1:0] addr_win;
  logic [PROBE_W-1:0]      probes;
  logic                    found;
  logic [WIN_W-1:0]        pos_found;
  logic [KEY_W-1:0]        rem;
  logic [QUO_W-1:0]        dq;
  logic [CNT_W-1:0]        cnt;

  logic [31:0]             widx;
  logic [31:0]             raddr32;
  logic [AW-1:0]           raddr;
  logic                    we;
  logic [KEY_W-1:0]        rd_raw;
  logic signed [KEY_W-1:0] rd_data;

  logic signed [KEY_W:0]   num_full;
  logic signed [KEY_W:0]   den_full;
  logic [KEY_W-1:0]        num;
  logic [KEY_W-1:0]        den;
  logic [WIN_W-1:0]        span_full;
  logic [QUO_W-1:0]        span;
  logic [PROD_W-1:0]       prod;
  logic [KEY_W:0]          trial;
  logic [KEY_W:0]          trial_sub;
  logic                    ge;

  assign n_eff = (32'(table_size) > 32'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH) : table_size;

  assign widx = 32'(req_entry_index);
  assign we   = cmd.write && (widx < 32'(TABLE_DEPTH));

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_HI:  addr_win = hi;
      ADDR_POS: addr_win = pos;
      default:  addr_win = lo;
    endcase
  end

  assign raddr32 = 32'($unsigned(addr_win));
  assign raddr   = raddr32[AW-1:0];

  isrch_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (widx[AW-1:0]),
    .wdata (req_key_value),
    .raddr (raddr),
    .rdata (rd_raw)
  );

  assign rd_data = $signed(rd_raw);

  assign num_full  = {key[KEY_W-1], key} - {vlo[KEY_W-1], vlo};
  assign den_full  = {vhi[KEY_W-1], vhi} - {vlo[KEY_W-1], vlo};
  assign num       = num_full[KEY_W-1:0];
  assign den       = den_full[KEY_W-1:0];
  assign span_full = $unsigned(hi - lo);
  assign span      = span_full[QUO_W-1:0];
  assign prod      = PROD_W'(span) * PROD_W'(num);

  assign trial     = {rem, dq[QUO_W-1]};
  assign trial_sub = trial - {1'b0, den};
  assign ge        = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= '0;
    end else if (cfg_wr_en) begin
      table_size <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key       <= req_key_value;
      lo        <= '0;
      hi        <= $signed(WIN_W'(n_eff)) - WIN_W'(1);
      pos       <= '0;
      probes    <= '0;
      found     <= 1'b0;
      pos_found <= '0;
    end
    if (cmd.cap_lo) begin
      vlo <= rd_data;
    end
    if (cmd.cap_hi) begin
      vhi <= rd_data;
    end
    if (cmd.count_probe) begin
      probes <= probes + PROBE_W'(1);
    end
    if (cmd.pos_from_lo) begin
      pos <= lo;
    end
    if (cmd.mul_load) begin
      rem <= prod[PROD_W-1:QUO_W];
      dq  <= prod[QUO_W-1:0];
      cnt <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? trial_sub[KEY_W-1:0] : trial[KEY_W-1:0];
      dq  <= {dq[QUO_W-2:0], ge};
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.pos_from_sum) begin
      pos <= lo + $signed({1'b0, dq});
    end
    if (cmd.narrow) begin
      if (rd_data < key) begin
        lo <= pos + WIN_W'(1);
      end else begin
        hi <= pos - WIN_W'(1);
      end
    end
    if (cmd.set_found) begin
      found     <= 1'b1;
      pos_found <= $unsigned(pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_found    <= found;
      rsp_position <= pos_found[IDX_W-1:0];
      rsp_probes   <= probes;
    end
  end

  always_comb begin
    st.is_search  = (req_command == CMD_SEARCH);
    st.n_zero     = (n_eff == '0);
    st.n_one      = (n_eff == SIZE_W'(1));
    st.win_empty  = (lo > hi);
    st.out_range  = (key < vlo) || (key > rd_data);
    st.ends_equal = (rd_data == vlo);
    st.div_last   = (cnt == CNT_W'(QUO_W - 1));
    st.hit        = (rd_data == key);
    st.out_free   = !rsp_valid || rsp_ready;
  end

endmodule

// ----- rtl/core/interpolation_search.sv -----
`timescale 1ns / 1ps

// Interpolation search over a sorted table of signed 32-bit keys.
// Request channel (req): command 0 writes key_value at entry_index;
// command 1 searches for key_value among the first table_size entries
// (at most TABLE_DEPTH). Configuration: cfg_wr_en with cfg_wr_data loads
// table_size; write it only while no search is in flight.
// Response channel (rsp): one beat per search carrying found, position
// and the probe count; writes return nothing.
// Each probe is a round: the table reads of lo, hi and the probe plus a
// restoring divide of span * (key - table[lo]) by table[hi] - table[lo];
// a probe with equal end values skips the divide. The search ends on a
// hit, when the window empties or when the key falls outside
// table[lo]..table[hi]; an empty table answers without a probe and a
// one-entry table after a single compare. Searches are handled one at
// a time; req is ready only while the block is idle.
// Reset clears table_size and the response valid flag; table contents
// are undefined until written. A stalled response is held in its output
// register; the next request is taken meanwhile, and a following search
// waits at its end until the held beat is taken.
module interpolation_search import isrch_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  isrch_req_if.sink         req,
  isrch_rsp_if.source       rsp
);

  isrch_cmd_t    cmd;
  isrch_status_t st;

  isrch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  isrch_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .req_command     (req.command),
    .req_entry_index (req.entry_index),
    .req_key_value   (req.key_value),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_found       (rsp.found),
    .rsp_position    (rsp.position),
    .rsp_probes      (rsp.probes),
    .cmd             (cmd),
    .st              (st)
  );

endmodule

// ----- rtl/core/isrch_checker.sv -----
`timescale 1ns / 1ps

module isrch_checker import isrch_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               req_command,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic               found,
  input logic [IDX_W-1:0]   position,
  input logic [PROBE_W-1:0] probes
);

  a_reset_clears_rsp: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable({found, position, probes}))
    else $error("stalled response changed");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> position == '0)
    else $error("miss reports nonzero position");

  a_write_no_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_command == CMD_WRITE && !rsp_valid |=> !rsp_valid)
    else $error("write beat produced a response");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_command == CMD_SEARCH |=> !req_ready)
    else $error("request taken during a search");

endmodule

bind interpolation_search isrch_checker u_isrch_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_command (req.command),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .found       (rsp.found),
  .position    (rsp.position),
  .probes      (rsp.probes)
);
